FILE: rtl/uihb_pkg.sv
// ----------------------------------------------------------------------------
// uihb_pkg
// Shared types, constants and the ones-complement fold for the UDP/IPv4
// header builder.
// ----------------------------------------------------------------------------
package uihb_pkg;

    localparam int MAX_PAYLOAD = 1500;
    localparam int LEN_W       = 11;
    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] VER_IHL   = 8'h45;
    localparam logic [7:0] IP_TTL    = 8'd64;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam int SUM_W = 20;

    localparam int WORD_IDX_W = 3;
    localparam logic [WORD_IDX_W-1:0] WORD_IDX_LAST = WORD_IDX_W'(6);

    localparam int FIFO_AW    = 1;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef struct packed {
        logic             dropped;
        logic [LEN_W-1:0] len;
        logic [15:0]      psum;
        logic [31:0]      source_address;
        logic [15:0]      source_port;
        logic [31:0]      dest_address;
        logic [15:0]      dest_port;
        logic [15:0]      ident;
    } uihb_desc_t;

    function automatic logic [15:0] oc_fold(input logic [SUM_W-1:0] x);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, x[15:0]} + 17'(x[SUM_W-1:16]);
        s2 = s1[15:0] + 16'(s1[16]);
        return s2;
    endfunction

endpackage

FILE: rtl/udp_ipv4_header_builder.sv
// ----------------------------------------------------------------------------
// udp_ipv4_header_builder
// Builds the 28-byte IPv4 plus UDP header for a payload streamed one byte at
// a time.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle without pause while the packet
// descriptor queue (two entries) has room. For each packet it sends seven
// 32-bit header words, one per cycle unless m_ready holds the output, or a
// single word flagged as dropped when the payload is longer than the limit.
// After the transfer of the last payload byte, the first header word passes
// through the descriptor queue, the address sum, the wide checksum sums, the
// checksum fold in the word sequencer and the output register. The sequencer
// sends one word per cycle unless m_ready holds it, so a stream of packets
// shorter than seven bytes is paced by the header output.
module udp_ipv4_header_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_last_byte,
    input  logic [31:0] s_source_address,
    input  logic [15:0] s_source_port,
    input  logic [31:0] s_dest_address,
    input  logic [15:0] s_dest_port,
    input  logic [15:0] s_ident,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [31:0] m_header_word,
    output logic        m_word_last,
    output logic        m_dropped,
    output logic        m_valid,
    input  logic        m_ready
);
    import uihb_pkg::*;

    uihb_desc_t front_desc;
    logic       front_valid;
    logic       front_ready;
    uihb_desc_t back_desc;
    logic       back_valid;
    logic       back_ready;

    uihb_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_payload_byte   (s_payload_byte),
        .s_last_byte      (s_last_byte),
        .s_source_address (s_source_address),
        .s_source_port    (s_source_port),
        .s_dest_address   (s_dest_address),
        .s_dest_port      (s_dest_port),
        .s_ident          (s_ident),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .desc             (front_desc),
        .desc_valid       (front_valid),
        .desc_ready       (front_ready)
    );

    uihb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_desc  (front_desc),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_desc  (back_desc),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    uihb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .desc          (back_desc),
        .desc_valid    (back_valid),
        .desc_ready    (back_ready),
        .m_header_word (m_header_word),
        .m_word_last   (m_word_last),
        .m_dropped     (m_dropped),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule

FILE: rtl/uihb_fifo.sv
// ----------------------------------------------------------------------------
// uihb_fifo
// Short descriptor queue between the payload front end and the header back
// end.
// ----------------------------------------------------------------------------
module uihb_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uihb_pkg::uihb_desc_t wr_desc,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    output uihb_pkg::uihb_desc_t rd_desc,
    output logic                 rd_valid,
    input  logic                 rd_ready
);
    import uihb_pkg::*;

    uihb_desc_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 push, pop;

    assign wr_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

FILE: rtl/uihb_front.sv
// ----------------------------------------------------------------------------
// uihb_front
// Accepts payload bytes, keeps the running ones-complement sum and byte count,
// and queues one packet descriptor per last byte.
// ----------------------------------------------------------------------------
module uihb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_payload_byte,
    input  logic                 s_last_byte,
    input  logic [31:0]          s_source_address,
    input  logic [15:0]          s_source_port,
    input  logic [31:0]          s_dest_address,
    input  logic [15:0]          s_dest_port,
    input  logic [15:0]          s_ident,
    input  logic                 s_valid,
    output logic                 s_ready,
    output uihb_pkg::uihb_desc_t desc,
    output logic                 desc_valid,
    input  logic                 desc_ready
);
    import uihb_pkg::*;

    logic [15:0]      running_sum_reg, running_sum_next;
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    logic             odd_pending_reg, odd_pending_next;

    logic             accept;
    logic [LEN_W-1:0] count_inc;
    logic [15:0]      pair_word;
    logic [16:0]      sum_add;
    logic [15:0]      sum_fold;

    assign s_ready = desc_ready;
    assign accept  = s_valid && s_ready;

    assign count_inc = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                     : byte_count_reg + 1'b1;
    assign pair_word = odd_pending_reg ? {held_byte_reg, s_payload_byte}
                                       : {s_payload_byte, 8'h00};
    assign sum_add   = {1'b0, running_sum_reg} + {1'b0, pair_word};
    assign sum_fold  = oc_fold(SUM_W'(sum_add));

    assign desc_valid          = accept && s_last_byte;
    assign desc.dropped        = (32'(count_inc) > 32'(MAX_PAYLOAD));
    assign desc.len            = count_inc;
    assign desc.psum           = sum_fold;
    assign desc.source_address = s_source_address;
    assign desc.source_port    = s_source_port;
    assign desc.dest_address   = s_dest_address;
    assign desc.dest_port      = s_dest_port;
    assign desc.ident          = s_ident;

    always_comb begin
        running_sum_next = running_sum_reg;
        byte_count_next  = byte_count_reg;
        held_byte_next   = held_byte_reg;
        odd_pending_next = odd_pending_reg;
        if (accept) begin
            if (s_last_byte) begin
                running_sum_next = '0;
                byte_count_next  = '0;
                held_byte_next   = '0;
                odd_pending_next = 1'b0;
            end else begin
                byte_count_next = count_inc;
                if (odd_pending_reg) begin
                    running_sum_next = sum_fold;
                    held_byte_next   = '0;
                    odd_pending_next = 1'b0;
                end else begin
                    held_byte_next   = s_payload_byte;
                    odd_pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
            byte_count_reg  <= '0;
            held_byte_reg   <= '0;
            odd_pending_reg <= 1'b0;
        end else begin
            running_sum_reg <= running_sum_next;
            byte_count_reg  <= byte_count_next;
            held_byte_reg   <= held_byte_next;
            odd_pending_reg <= odd_pending_next;
        end
    end

endmodule

FILE: rtl/uihb_back.sv
// ----------------------------------------------------------------------------
// uihb_back
// Checksum pipeline and word sequencer: sums the header terms over two
// stages, folds them, and sends the seven header words, or a single word for
// a dropped packet, through an output register.
// ----------------------------------------------------------------------------
module uihb_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uihb_pkg::uihb_desc_t desc,
    input  logic                 desc_valid,
    output logic                 desc_ready,
    output logic [31:0]          m_header_word,
    output logic                 m_word_last,
    output logic                 m_dropped,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import uihb_pkg::*;

    localparam logic [SUM_W-1:0] IP_SUM_CONST =
        SUM_W'({VER_IHL, 8'h00}) + SUM_W'({IP_TTL, PROTO_UDP});

    // Stage 1: address sum and lengths.
    logic             s1_valid_reg, s1_valid_next;
    uihb_desc_t       s1_desc_reg;
    logic [SUM_W-1:0] s1_addr_sum_reg;
    logic [15:0]      s1_tot_reg;
    logic [15:0]      s1_ulen_reg;
    logic             s1_ready;

    // Stage 2: wide checksum sums.
    logic             s2_valid_reg, s2_valid_next;
    uihb_desc_t       s2_desc_reg;
    logic [15:0]      s2_tot_reg;
    logic [15:0]      s2_ulen_reg;
    logic [SUM_W-1:0] s2_ip_sum_reg;
    logic [SUM_W-1:0] s2_udp_sum_reg;
    logic             s2_ready;

    // Word sequencer.
    logic                  em_busy_reg, em_busy_next;
    logic [WORD_IDX_W-1:0] em_idx_reg, em_idx_next;
    uihb_desc_t            em_desc_reg;
    logic [15:0]           em_tot_reg;
    logic [15:0]           em_ulen_reg;
    logic [15:0]           em_ipc_reg;
    logic [15:0]           em_udc_reg;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_header_word_reg;
    logic        m_word_last_reg;
    logic        m_dropped_reg;

    logic        s1_load, s2_load, em_load, out_free, em_step, em_finish;
    logic        em_is_last;
    logic [15:0] ip_fold, udp_fold, udc_raw;
    logic [31:0] word_sel;

    assign out_free   = !m_valid_reg || m_ready;
    assign em_is_last = em_desc_reg.dropped || (em_idx_reg == WORD_IDX_LAST);
    assign em_step    = em_busy_reg && out_free;
    assign em_finish  = em_step && em_is_last;
    assign em_load    = s2_valid_reg && (!em_busy_reg || em_finish);

    assign s2_ready   = !s2_valid_reg || em_load;
    assign s2_load    = s1_valid_reg && s2_ready;
    assign s1_ready   = !s1_valid_reg || s2_load;
    assign desc_ready = s1_ready;
    assign s1_load    = desc_valid && s1_ready;

    assign ip_fold  = oc_fold(s2_ip_sum_reg);
    assign udp_fold = oc_fold(s2_udp_sum_reg);
    assign udc_raw  = ~udp_fold;

    always_comb begin
        case (em_idx_reg)
            3'd0:    word_sel = {VER_IHL, 8'h00, em_tot_reg};
            3'd1:    word_sel = {em_desc_reg.ident, 16'h0000};
            3'd2:    word_sel = {IP_TTL, PROTO_UDP, em_ipc_reg};
            3'd3:    word_sel = em_desc_reg.source_address;
            3'd4:    word_sel = em_desc_reg.dest_address;
            3'd5:    word_sel = {em_desc_reg.source_port, em_desc_reg.dest_port};
            default: word_sel = {em_ulen_reg, em_udc_reg};
        endcase
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (s2_load) begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s2_load) begin
            s2_valid_next = 1'b1;
        end else if (em_load) begin
            s2_valid_next = 1'b0;
        end

        em_busy_next = em_busy_reg;
        em_idx_next  = em_idx_reg;
        if (em_load) begin
            em_busy_next = 1'b1;
            em_idx_next  = '0;
        end else if (em_finish) begin
            em_busy_next = 1'b0;
        end else if (em_step) begin
            em_idx_next = em_idx_reg + 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = em_busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            em_busy_reg  <= 1'b0;
            em_idx_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            em_busy_reg  <= em_busy_next;
            em_idx_reg   <= em_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_desc_reg     <= desc;
            s1_addr_sum_reg <= SUM_W'(desc.source_address[31:16])
                             + SUM_W'(desc.source_address[15:0])
                             + SUM_W'(desc.dest_address[31:16])
                             + SUM_W'(desc.dest_address[15:0]);
            s1_tot_reg      <= 16'(desc.len) + 16'd28;
            s1_ulen_reg     <= 16'(desc.len) + 16'd8;
        end
        if (s2_load) begin
            s2_desc_reg    <= s1_desc_reg;
            s2_tot_reg     <= s1_tot_reg;
            s2_ulen_reg    <= s1_ulen_reg;
            s2_ip_sum_reg  <= s1_addr_sum_reg + IP_SUM_CONST
                            + SUM_W'(s1_tot_reg)
                            + SUM_W'(s1_desc_reg.ident);
            s2_udp_sum_reg <= s1_addr_sum_reg
                            + SUM_W'(s1_desc_reg.psum)
                            + SUM_W'(PROTO_UDP)
                            + SUM_W'({s1_ulen_reg, 1'b0})
                            + SUM_W'(s1_desc_reg.source_port)
                            + SUM_W'(s1_desc_reg.dest_port);
        end
        if (em_load) begin
            em_desc_reg <= s2_desc_reg;
            em_tot_reg  <= s2_tot_reg;
            em_ulen_reg <= s2_ulen_reg;
            em_ipc_reg  <= ~ip_fold;
            em_udc_reg  <= (udc_raw == 16'h0000) ? 16'hffff : udc_raw;
        end
        if (em_step) begin
            m_header_word_reg <= em_desc_reg.dropped ? 32'h0 : word_sel;
            m_word_last_reg   <= em_is_last;
            m_dropped_reg     <= em_desc_reg.dropped;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_header_word = m_header_word_reg;
    assign m_word_last   = m_word_last_reg;
    assign m_dropped     = m_dropped_reg;

endmodule
